// ===== hdl/bms_pkg.sv =====
package bms_pkg;

  // run capacity and element width
  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(MAX_ITEMS);

  // contents of one insertion cell
  typedef struct packed {
    logic                          valid;
    logic signed [VALUE_WIDTH-1:0] value;
  } slot_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic                          ins;
    logic                          shift;
    logic signed [VALUE_WIDTH-1:0] value;
  } ctrl_t;

endpackage

// ===== hdl/bms_stream_if.sv =====
interface bms_stream_if;
  import bms_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface

// ===== hdl/bms_cell.sv =====
module bms_cell (
  input  logic          clk,
  input  logic          rst,
  input  bms_pkg::ctrl_t ctrl,
  input  bms_pkg::slot_t prev,
  input  bms_pkg::slot_t next,
  output bms_pkg::slot_t slot
);
  import bms_pkg::*;

  logic                          valid;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          keep;
  logic                          take_prev;
  logic                          load;

  // insertion decision: keep a smaller-or-equal value, else shift up or take the new one
  assign keep      = valid && (value <= ctrl.value);
  assign take_prev = prev.valid && (prev.value > ctrl.value);
  // a cell only fills when the cell below it is occupied
  assign load      = ctrl.ins && !keep && prev.valid;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next.valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  // held value
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next.value;
    end else if (load) begin
      value <= take_prev ? prev.value : ctrl.value;
    end
  end

  assign slot = '{valid: valid, value: value};

endmodule

// ===== hdl/block_merge_sorter.sv =====
// Sorts runs of up to MAX_ITEMS signed values. Input beats are taken one per
// cycle into a row of MAX_ITEMS insertion cells that keep the run in ascending
// order as it arrives. A beat with last set, or the beat that fills the row,
// ends the run: the row then drains from its low end, one value per output
// beat, smallest first, with last set on the largest. No input beat is
// accepted while the row drains, and the next run can start in the cycle
// after the final output beat. Output stalls simply hold the row.
module block_merge_sorter (
  input  logic         clk,
  input  logic         rst,
  bms_stream_if.sink   in_ch,
  bms_stream_if.source out_ch
);
  import bms_pkg::*;

  typedef enum logic {LOAD, DRAIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  ctrl_t            ctrl;
  slot_t            slots [MAX_ITEMS];
  slot_t            empty_slot;
  slot_t            floor_slot;
  logic             in_beat;
  logic             out_beat;
  logic             run_end;

  assign empty_slot = '{valid: 1'b0, value: '0};
  // always occupied, smallest possible value: lets the first cell take any value
  assign floor_slot = '{valid: 1'b1, value: {1'b1, {(VALUE_WIDTH-1){1'b0}}}};

  // handshakes
  assign in_ch.ready   = (state == LOAD);
  assign in_beat       = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = (state == DRAIN) && slots[0].valid;
  assign out_ch.value  = slots[0].value;
  assign out_ch.last   = !slots[1].valid;
  assign out_beat      = out_ch.valid && out_ch.ready;
  assign run_end       = in_ch.last || (count == CNT_W'(MAX_ITEMS - 1));

  // cell control
  assign ctrl = '{ins: in_beat, shift: out_beat, value: in_ch.value};

  // load / drain sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LOAD;
      count <= '0;
    end else begin
      case (state)
        LOAD: begin
          if (in_beat) begin
            if (run_end) begin
              state <= DRAIN;
              count <= '0;
            end else begin
              count <= count + 1'b1;
            end
          end
        end
        DRAIN: begin
          if (out_beat && out_ch.last) begin
            state <= LOAD;
          end
        end
        default: begin
          state <= LOAD;
          count <= '0;
        end
      endcase
    end
  end

  // insertion cell row
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    slot_t prev_slot;
    slot_t next_slot;

    if (i == 0) begin : g_first
      assign prev_slot = floor_slot;
    end else begin : g_mid
      assign prev_slot = slots[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_last
      assign next_slot = empty_slot;
    end else begin : g_inner
      assign next_slot = slots[i+1];
    end

    bms_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (ctrl),
      .prev (prev_slot),
      .next (next_slot),
      .slot (slots[i])
    );
  end

`ifndef SYNTH
  // no input is taken while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready)
    else $error("input accepted during drain");

  // a run-ending beat is followed by output
  a_end_drains: assert property (@(posedge clk) disable iff (rst)
    (in_beat && in_ch.last) |=> out_ch.valid)
    else $error("run end did not start drain");

  // final output beat returns the block to loading
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_beat && out_ch.last) |=> in_ch.ready)
    else $error("block not ready after final beat");

  // head of the row is ordered
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    slots[1].valid |-> (slots[0].valid && (slots[0].value <= slots[1].value)))
    else $error("cell row out of order");
`endif

endmodule
